// ===== design/tgc_pkg.sv =====
// tgc_pkg: shared types and constants for the touch gesture classifier
`timescale 1ns / 1ps
`default_nettype none

package tgc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd800;
    localparam logic [CFG_W-1:0] DTAP_WIN_RESET   = 16'd300;

    typedef enum logic {
        CFG_LONG_PRESS = 1'b0,
        CFG_DTAP_WIN   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_TAP    = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_LONG   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] double_tap_window_ms;
    } t_cfg;

    typedef struct packed {
        logic              press_active;
        logic              long_reported;
        logic              tap_waiting;
        logic [TIME_W-1:0] press_start_ms;
        logic [TIME_W-1:0] tap_release_ms;
        logic [TIME_W-1:0] activity_ms;
    } t_state;

    typedef struct packed {
        logic              gesture_valid;
        t_kind             gesture_kind;
        logic [TIME_W-1:0] last_activity_ms;
    } t_result;

endpackage

`default_nettype wire

// ===== design/tgc_cfg.sv =====
// tgc_cfg: configuration registers for hold time and double-tap window
`timescale 1ns / 1ps
`default_nettype none

module tgc_cfg
    import tgc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms        <= LONG_PRESS_RESET;
            r_cfg.double_tap_window_ms <= DTAP_WIN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LONG_PRESS: r_cfg.long_press_ms        <= i_cfg_data;
                CFG_DTAP_WIN:   r_cfg.double_tap_window_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/tgc_step.sv =====
// tgc_step: next-state and gesture logic for one poll
`timescale 1ns / 1ps
`default_nettype none

module tgc_step
    import tgc_pkg::*;
(
    input  wire t_cfg              i_cfg,
    input  wire t_state            i_state,
    input  wire logic              i_touched,
    input  wire logic [TIME_W-1:0] i_now_ms,
    output t_state                 o_state,
    output t_result                o_result
);

    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] win;
    t_state            s;
    logic              valid;
    t_kind             kind;

    always_comb begin
        // zero hold time acts as one so a press start never fires a long press
        hold = (i_cfg.long_press_ms == '0) ? TIME_W'(1)
                                           : TIME_W'(i_cfg.long_press_ms);
        win  = TIME_W'(i_cfg.double_tap_window_ms);
        s     = i_state;
        valid = 1'b0;
        kind  = KIND_TAP;

        if (i_touched && !s.press_active) begin
            s.press_active   = 1'b1;
            s.press_start_ms = i_now_ms;
            s.long_reported  = 1'b0;
            if (s.tap_waiting && (i_now_ms - s.tap_release_ms) <= win) begin
                s.tap_waiting  = 1'b0;
                valid          = 1'b1;
                kind           = KIND_DOUBLE;
                s.activity_ms  = i_now_ms;
            end
        end

        if (s.press_active && !s.long_reported && (i_now_ms - s.press_start_ms) >= hold) begin
            s.long_reported = 1'b1;
            s.tap_waiting   = 1'b0;
            valid           = 1'b1;
            kind            = KIND_LONG;
            s.activity_ms   = i_now_ms;
        end

        if (!i_touched && s.press_active) begin
            s.press_active = 1'b0;
            if (!s.long_reported && (i_now_ms - s.press_start_ms) < hold) begin
                s.tap_waiting    = 1'b1;
                s.tap_release_ms = i_now_ms;
            end
            s.activity_ms = i_now_ms;
        end

        // pending tap expires only while released
        if (s.tap_waiting && !s.press_active && (i_now_ms - s.tap_release_ms) > win) begin
            s.tap_waiting = 1'b0;
            valid         = 1'b1;
            kind          = KIND_TAP;
        end
    end

    assign o_state                   = s;
    assign o_result.gesture_valid    = valid;
    assign o_result.gesture_kind     = kind;
    assign o_result.last_activity_ms = s.activity_ms;

endmodule

`default_nettype wire

// ===== design/touch_gesture_classifier_core.sv =====
// touch_gesture_classifier_core: top level of the tap / double tap / long press classifier
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_touched, i_now_ms
//  out     | output    | o_out_valid / i_out_ready | o_gesture_valid, o_gesture_kind,
//          |           |                          | o_last_activity_ms
//  cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  one item per cycle sustained while i_out_ready stays high; an accepted item's result
//  passes through the input register, then classify logic into the result register
//  gesture state updates as an item moves from the input register to the result register
//  a stalled result holds the input register; o_in_ready follows i_out_ready combinationally
//  synchronous active-low reset clears the state and both valid flags and restores the config defaults
`timescale 1ns / 1ps
`default_nettype none

module touch_gesture_classifier_core
    import tgc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_touched,
    input  wire logic [TIME_W-1:0] i_now_ms,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_gesture_valid,
    output logic [1:0]             o_gesture_kind,
    output logic [TIME_W-1:0]      o_last_activity_ms,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    t_cfg              cfg;
    t_state            r_state;
    t_state            n_state;
    t_result           n_result;
    t_result           r_result;
    logic              r_in_valid;
    logic              r_touched;
    logic [TIME_W-1:0] r_now_ms;
    logic              r_out_valid;
    logic              advance;

    tgc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tgc_step u_step (
        .i_cfg     (cfg),
        .i_state   (r_state),
        .i_touched (r_touched),
        .i_now_ms  (r_now_ms),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_touched <= i_touched;
            r_now_ms  <= i_now_ms;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_gesture_valid    = r_result.gesture_valid;
    assign o_gesture_kind     = r_result.gesture_kind;
    assign o_last_activity_ms = r_result.last_activity_ms;

    a_no_kind_without_gesture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_gesture_valid |-> o_gesture_kind == KIND_TAP)
        else $error("gesture kind set without a gesture");

    a_long_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.gesture_valid && n_result.gesture_kind == KIND_LONG
        |=> r_state.long_reported && !r_state.tap_waiting)
        else $error("long press did not latch its flag");

    a_double_clears_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_result.gesture_valid && n_result.gesture_kind == KIND_DOUBLE
        |=> !r_state.tap_waiting && r_state.press_active)
        else $error("double tap left a pending tap");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result stalled");

    a_state_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without an item");

endmodule

`default_nettype wire
